// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the heap RTL.
// Depends on nothing; taken in by the top level with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, held off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/amh_pkg.sv =====
// Shared types and constants for the addressable min-heap.
// Used by amh_ctrl, amh_dp and addressable_min_heap_top.
package amh_pkg;

   localparam int CAPACITY     = 256;
   localparam int HANDLE_COUNT = 256;
   localparam int KEY_BITS     = 32;
   localparam int SLOT_BITS    = $clog2(CAPACITY + 1);
   localparam int HADDR_BITS   = $clog2(CAPACITY);
   localparam int HND_BITS     = 8;

   typedef logic signed [KEY_BITS-1:0] key_type;
   typedef logic [SLOT_BITS-1:0]       slot_type;
   typedef logic [HND_BITS-1:0]        hnd_type;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_EXTRACT = 3'd1,
      OP_CHANGE  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_PEEK    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_PRESENT = 3'd3,
      ST_ABSENT  = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      C_IDLE, C_ACCEPT, C_SET_ST, C_INS, C_EX_RD, C_EX_KEY, C_EX_GOT,
      C_CK_RD, C_CK_SET, C_RM, C_TK0, C_TK1, C_TK2, C_UP0, C_UP1,
      C_UP_MOVE, C_PLACE, C_DN0, C_DN1, C_DN2, C_DN3, C_DN_MOVE,
      C_FIN0, C_FIN1, C_FIN2
   } code_type;

   typedef struct packed {
      code_type   code;
      status_type st;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       inrange;
      logic       present;
      logic       full;
      logic       empty;
      logic       slot_le1;
      logic       key_gt;
      logic       key_lt;
      logic       parent_gt;
      logic       l_ok;
      logic       tk_past;
      logic       dn_stay;
      logic       from_take;
   } stat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_EX1, S_EX2, S_CK1, S_TK0, S_TK1, S_TK2,
      S_UP0, S_UP1, S_UP2, S_DN0, S_DN1, S_DN2, S_DN3, S_DN4,
      S_FIN, S_F1, S_F2, S_OUT
   } state_type;

endpackage

// ===== rtl/addressable_min_heap_top.sv =====
// Channel   Ports                         Direction
// request   req_valid/req_stall, fields   in
// response  rsp_valid/rsp_stall, fields   out
//
// One word is taken at a time. Sift up and sift down move one level per pass,
// paced by the single read port of the slot and key memories. Reset is
// synchronous and empties the heap at once. A stalled response holds the
// block until the word is taken.
// Depends on amh_pkg, amh_ctrl, amh_dp and assert_macros.svh.
`include "assert_macros.svh"

module addressable_min_heap_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_operation,
   input  logic [7:0]           req_handle,
   input  logic signed [31:0]   req_new_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic                 rsp_min_valid,
   output logic [7:0]           rsp_min_handle,
   output logic signed [31:0]   rsp_min_key,
   output logic [8:0]           rsp_element_count
);

   amh_pkg::cmd_type  cmd;
   amh_pkg::stat_type stat;

   amh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   amh_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_handle        (req_handle),
      .req_new_key       (req_new_key),
      .rsp_status        (rsp_status),
      .rsp_min_valid     (rsp_min_valid),
      .rsp_min_handle    (rsp_min_handle),
      .rsp_min_key       (rsp_min_key),
      .rsp_element_count (rsp_element_count)
   );

   `ASSERT_CLK(a_no_accept_busy, clock, rsp_valid |-> req_stall, "request taken while busy")
   `ASSERT_CLK_RST(a_count_cap, clock, reset,
      32'(rsp_element_count) <= amh_pkg::CAPACITY, "count over capacity")
   `ASSERT_CLK_RST(a_empty_zero, clock, reset,
      (rsp_valid && !rsp_min_valid) |-> (rsp_min_handle == '0 && rsp_min_key == '0),
      "fields not cleared")
   `ASSERT_CLK_RST(a_empty_count, clock, reset,
      (rsp_valid && rsp_status == amh_pkg::ST_EMPTY) |-> (rsp_element_count == '0),
      "empty status with elements")

endmodule

// ===== rtl/amh_dp.sv =====
// Heap datapath: heap slot, key and position memories plus working registers.
// Depends on amh_pkg; driven by commands from amh_ctrl.
module amh_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  amh_pkg::cmd_type         cmd,
   output amh_pkg::stat_type        stat,
   input  logic [2:0]               req_operation,
   input  amh_pkg::hnd_type         req_handle,
   input  logic signed [31:0]       req_new_key,
   output logic [2:0]               rsp_status,
   output logic                     rsp_min_valid,
   output amh_pkg::hnd_type         rsp_min_handle,
   output logic signed [31:0]       rsp_min_key,
   output logic [8:0]               rsp_element_count
);

   logic [amh_pkg::HND_BITS-1:0]   heap_mem [amh_pkg::CAPACITY];
   amh_pkg::key_type               key_mem  [amh_pkg::HANDLE_COUNT];
   amh_pkg::slot_type              pos_mem  [amh_pkg::HANDLE_COUNT];
   logic [amh_pkg::HANDLE_COUNT-1:0] pos_vld_ff;

   logic [2:0]          op_ff, op_in;
   amh_pkg::hnd_type    hnd_ff, hnd_in, mover_ff, mover_in, ph_ff, ph_in;
   amh_pkg::hnd_type    lh_ff, lh_in, rh_ff, rh_in, rmh_ff, rmh_in;
   amh_pkg::key_type    nkey_ff, nkey_in, mkey_ff, mkey_in, lk_ff, lk_in;
   amh_pkg::key_type    rk_ff, rk_in, rmk_ff, rmk_in;
   amh_pkg::slot_type   cnt_ff, cnt_in, slot_ff, slot_in, tslot_ff, tslot_in;
   logic [2:0]          rst_ff, rst_in;
   logic                rvalid_ff, rvalid_in, take_ff, take_in;
   amh_pkg::hnd_type    heap_q_ff;
   amh_pkg::key_type    key_q_ff;
   amh_pkg::slot_type   pos_q_ff;

   logic                heap_rd, key_rd, key_wr, place_en, pos_rd, pos_clr;
   logic [amh_pkg::SLOT_BITS:0] heap_rs;
   amh_pkg::hnd_type    key_ra, pos_ra, place_h;
   amh_pkg::slot_type   place_slot;
   logic [amh_pkg::HADDR_BITS-1:0] heap_ra, heap_wa;

   logic [amh_pkg::SLOT_BITS:0] l_slot, r_slot;
   logic                l_ok, r_ok, lsel, rsel;
   amh_pkg::key_type    best;
   amh_pkg::slot_type   s_slot;
   amh_pkg::hnd_type    child;

   assign l_slot = {slot_ff, 1'b0};
   assign r_slot = l_slot + 1'b1;
   assign l_ok   = l_slot <= {1'b0, cnt_ff};
   assign r_ok   = r_slot <= {1'b0, cnt_ff};
   assign lsel   = l_ok && (lk_ff < mkey_ff);
   assign best   = lsel ? lk_ff : mkey_ff;
   assign rsel   = r_ok && (rk_ff < best);
   assign s_slot = rsel ? r_slot[amh_pkg::SLOT_BITS-1:0] : l_slot[amh_pkg::SLOT_BITS-1:0];
   assign child  = rsel ? rh_ff : lh_ff;

   always_comb begin
      stat.op        = op_ff;
      stat.inrange   = 32'(hnd_ff) < amh_pkg::HANDLE_COUNT;
      stat.present   = pos_q_ff != '0;
      stat.full      = 32'(cnt_ff) >= amh_pkg::CAPACITY;
      stat.empty     = cnt_ff == '0;
      stat.slot_le1  = slot_ff <= amh_pkg::slot_type'(1);
      stat.key_gt    = nkey_ff > key_q_ff;
      stat.key_lt    = nkey_ff < key_q_ff;
      stat.parent_gt = key_q_ff > mkey_ff;
      stat.l_ok      = l_ok;
      stat.tk_past   = tslot_ff > cnt_ff;
      stat.dn_stay   = !lsel && !rsel;
      stat.from_take = take_ff;
   end

   always_comb begin
      op_in = op_ff;   hnd_in = hnd_ff;   nkey_in = nkey_ff;   cnt_in = cnt_ff;
      slot_in = slot_ff;   tslot_in = tslot_ff;   mover_in = mover_ff;
      mkey_in = mkey_ff;   ph_in = ph_ff;   lh_in = lh_ff;   lk_in = lk_ff;
      rh_in = rh_ff;   rk_in = rk_ff;   rst_in = rst_ff;   rvalid_in = rvalid_ff;
      rmh_in = rmh_ff;   rmk_in = rmk_ff;   take_in = take_ff;
      heap_rd = 1'b0;   heap_rs = '0;   key_rd = 1'b0;   key_ra = hnd_ff;
      key_wr = 1'b0;   place_en = 1'b0;   place_slot = slot_ff;   place_h = mover_ff;
      pos_rd = 1'b0;   pos_ra = hnd_ff;   pos_clr = 1'b0;
      case (cmd.code)
         amh_pkg::C_ACCEPT: begin
            op_in = req_operation;   hnd_in = req_handle;
            nkey_in = amh_pkg::key_type'(req_new_key);
            pos_rd = 1'b1;   pos_ra = req_handle;
            rst_in = amh_pkg::ST_OK;   rvalid_in = 1'b0;   take_in = 1'b0;
         end
         amh_pkg::C_SET_ST: rst_in = cmd.st;
         amh_pkg::C_INS: begin
            key_wr = 1'b1;   cnt_in = cnt_ff + 1'b1;   slot_in = cnt_ff + 1'b1;
            mover_in = hnd_ff;   mkey_in = nkey_ff;
         end
         amh_pkg::C_EX_RD: begin
            heap_rd = 1'b1;   heap_rs = (amh_pkg::SLOT_BITS+1)'(1);
         end
         amh_pkg::C_EX_KEY: begin
            rmh_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
            pos_clr = 1'b1;   pos_ra = heap_q_ff;
         end
         amh_pkg::C_EX_GOT: begin
            rmk_in = key_q_ff;   rvalid_in = 1'b1;   tslot_in = amh_pkg::slot_type'(1);
         end
         amh_pkg::C_CK_RD: key_rd = 1'b1;
         amh_pkg::C_CK_SET: begin
            key_wr = 1'b1;   slot_in = pos_q_ff;   mover_in = hnd_ff;   mkey_in = nkey_ff;
         end
         amh_pkg::C_RM: begin
            pos_clr = 1'b1;   tslot_in = pos_q_ff;
         end
         amh_pkg::C_TK0: begin
            heap_rd = 1'b1;   heap_rs = {1'b0, cnt_ff};   cnt_in = cnt_ff - 1'b1;
         end
         amh_pkg::C_TK1: begin
            mover_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
            slot_in = tslot_ff;   take_in = 1'b1;
         end
         amh_pkg::C_TK2: mkey_in = key_q_ff;
         amh_pkg::C_UP0: begin
            heap_rd = 1'b1;   heap_rs = {2'b00, slot_ff[amh_pkg::SLOT_BITS-1:1]};
         end
         amh_pkg::C_UP1: begin
            ph_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
         end
         amh_pkg::C_UP_MOVE: begin
            place_en = 1'b1;   place_h = ph_ff;
            slot_in = {1'b0, slot_ff[amh_pkg::SLOT_BITS-1:1]};   take_in = 1'b0;
         end
         amh_pkg::C_PLACE: place_en = 1'b1;
         amh_pkg::C_DN0: begin
            heap_rd = 1'b1;   heap_rs = l_slot;
         end
         amh_pkg::C_DN1: begin
            lh_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
            heap_rd = 1'b1;   heap_rs = r_slot;
         end
         amh_pkg::C_DN2: begin
            lk_in = key_q_ff;   rh_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
         end
         amh_pkg::C_DN3: rk_in = key_q_ff;
         amh_pkg::C_DN_MOVE: begin
            place_en = 1'b1;   place_h = child;   slot_in = s_slot;
         end
         amh_pkg::C_FIN0: begin
            heap_rd = 1'b1;   heap_rs = (amh_pkg::SLOT_BITS+1)'(1);
         end
         amh_pkg::C_FIN1: begin
            rmh_in = heap_q_ff;   key_rd = 1'b1;   key_ra = heap_q_ff;
         end
         amh_pkg::C_FIN2: begin
            rmk_in = key_q_ff;   rvalid_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign heap_ra = amh_pkg::HADDR_BITS'(heap_rs - 1'b1);
   assign heap_wa = amh_pkg::HADDR_BITS'(place_slot - 1'b1);

   always_ff @(posedge clock) begin
      if (heap_rd) begin
         heap_q_ff <= heap_mem[heap_ra];
      end
      if (place_en) begin
         heap_mem[heap_wa] <= place_h;
      end
      if (key_rd) begin
         key_q_ff <= key_mem[key_ra];
      end
      if (key_wr) begin
         key_mem[hnd_ff] <= nkey_ff;
      end
      if (pos_rd) begin
         pos_q_ff <= pos_vld_ff[pos_ra] ? pos_mem[pos_ra] : '0;
      end
      if (place_en) begin
         pos_mem[place_h] <= place_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= '0;
         cnt_ff     <= '0;
         take_ff    <= 1'b0;
         rvalid_ff  <= 1'b0;
         rst_ff     <= amh_pkg::ST_OK;
      end else begin
         if (place_en) begin
            pos_vld_ff[place_h] <= 1'b1;
         end else if (pos_clr) begin
            pos_vld_ff[pos_ra] <= 1'b0;
         end
         cnt_ff    <= cnt_in;
         take_ff   <= take_in;
         rvalid_ff <= rvalid_in;
         rst_ff    <= rst_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;   hnd_ff <= hnd_in;   nkey_ff <= nkey_in;   slot_ff <= slot_in;
      tslot_ff <= tslot_in;   mover_ff <= mover_in;   mkey_ff <= mkey_in;   ph_ff <= ph_in;
      lh_ff <= lh_in;   lk_ff <= lk_in;   rh_ff <= rh_in;   rk_ff <= rk_in;
      rmh_ff <= rmh_in;   rmk_ff <= rmk_in;
   end

   assign rsp_status        = rst_ff;
   assign rsp_min_valid     = rvalid_ff;
   assign rsp_min_handle    = rvalid_ff ? rmh_ff : '0;
   assign rsp_min_key       = rvalid_ff ? 32'(rmk_ff) : '0;
   assign rsp_element_count = 9'(cnt_ff);

endmodule

// ===== rtl/amh_ctrl.sv =====
// Heap controller: sequences each request through the datapath steps.
// Depends on amh_pkg; commands amh_dp and drives the handshakes.
module amh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  amh_pkg::stat_type  stat,
   output amh_pkg::cmd_type   cmd
);

   amh_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amh_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.code  = amh_pkg::C_IDLE;
      cmd.st    = amh_pkg::ST_OK;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         amh_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.code = amh_pkg::C_ACCEPT;
               state_in = amh_pkg::S_DEC;
            end
         end
         amh_pkg::S_DEC: begin
            state_in = amh_pkg::S_FIN;
            cmd.code = amh_pkg::C_SET_ST;
            case (stat.op)
               amh_pkg::OP_INSERT: begin
                  if (!stat.inrange) begin
                     cmd.st = amh_pkg::ST_ABSENT;
                  end else if (stat.present) begin
                     cmd.st = amh_pkg::ST_PRESENT;
                  end else if (stat.full) begin
                     cmd.st = amh_pkg::ST_FULL;
                  end else begin
                     cmd.code = amh_pkg::C_INS;
                     state_in = amh_pkg::S_UP0;
                  end
               end
               amh_pkg::OP_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.st = amh_pkg::ST_EMPTY;
                  end else begin
                     cmd.code = amh_pkg::C_EX_RD;
                     state_in = amh_pkg::S_EX1;
                  end
               end
               amh_pkg::OP_CHANGE: begin
                  if (!stat.inrange) begin
                     cmd.st = amh_pkg::ST_ABSENT;
                  end else if (!stat.present && stat.full) begin
                     cmd.st = amh_pkg::ST_FULL;
                  end else if (!stat.present) begin
                     cmd.code = amh_pkg::C_INS;
                     state_in = amh_pkg::S_UP0;
                  end else begin
                     cmd.code = amh_pkg::C_CK_RD;
                     state_in = amh_pkg::S_CK1;
                  end
               end
               amh_pkg::OP_REMOVE: begin
                  if (!stat.inrange || !stat.present) begin
                     cmd.st = amh_pkg::ST_ABSENT;
                  end else begin
                     cmd.code = amh_pkg::C_RM;
                     state_in = amh_pkg::S_TK0;
                  end
               end
               default: begin
                  cmd.st = stat.empty ? amh_pkg::ST_EMPTY : amh_pkg::ST_OK;
               end
            endcase
         end
         amh_pkg::S_EX1: begin
            cmd.code = amh_pkg::C_EX_KEY;
            state_in = amh_pkg::S_EX2;
         end
         amh_pkg::S_EX2: begin
            cmd.code = amh_pkg::C_EX_GOT;
            state_in = amh_pkg::S_TK0;
         end
         amh_pkg::S_CK1: begin
            if (stat.key_gt) begin
               cmd.code = amh_pkg::C_CK_SET;
               state_in = amh_pkg::S_DN0;
            end else if (stat.key_lt) begin
               cmd.code = amh_pkg::C_CK_SET;
               state_in = amh_pkg::S_UP0;
            end else begin
               state_in = amh_pkg::S_FIN;
            end
         end
         amh_pkg::S_TK0: begin
            cmd.code = amh_pkg::C_TK0;
            state_in = amh_pkg::S_TK1;
         end
         amh_pkg::S_TK1: begin
            if (stat.tk_past) begin
               state_in = amh_pkg::S_FIN;
            end else begin
               cmd.code = amh_pkg::C_TK1;
               state_in = amh_pkg::S_TK2;
            end
         end
         amh_pkg::S_TK2: begin
            cmd.code = amh_pkg::C_TK2;
            state_in = amh_pkg::S_UP0;
         end
         amh_pkg::S_UP0: begin
            if (stat.slot_le1 && stat.from_take) begin
               state_in = amh_pkg::S_DN0;
            end else if (stat.slot_le1) begin
               cmd.code = amh_pkg::C_PLACE;
               state_in = amh_pkg::S_FIN;
            end else begin
               cmd.code = amh_pkg::C_UP0;
               state_in = amh_pkg::S_UP1;
            end
         end
         amh_pkg::S_UP1: begin
            cmd.code = amh_pkg::C_UP1;
            state_in = amh_pkg::S_UP2;
         end
         amh_pkg::S_UP2: begin
            if (stat.parent_gt) begin
               cmd.code = amh_pkg::C_UP_MOVE;
               state_in = amh_pkg::S_UP0;
            end else if (stat.from_take) begin
               state_in = amh_pkg::S_DN0;
            end else begin
               cmd.code = amh_pkg::C_PLACE;
               state_in = amh_pkg::S_FIN;
            end
         end
         amh_pkg::S_DN0: begin
            if (stat.l_ok) begin
               cmd.code = amh_pkg::C_DN0;
               state_in = amh_pkg::S_DN1;
            end else begin
               cmd.code = amh_pkg::C_PLACE;
               state_in = amh_pkg::S_FIN;
            end
         end
         amh_pkg::S_DN1: begin
            cmd.code = amh_pkg::C_DN1;
            state_in = amh_pkg::S_DN2;
         end
         amh_pkg::S_DN2: begin
            cmd.code = amh_pkg::C_DN2;
            state_in = amh_pkg::S_DN3;
         end
         amh_pkg::S_DN3: begin
            cmd.code = amh_pkg::C_DN3;
            state_in = amh_pkg::S_DN4;
         end
         amh_pkg::S_DN4: begin
            if (stat.dn_stay) begin
               cmd.code = amh_pkg::C_PLACE;
               state_in = amh_pkg::S_FIN;
            end else begin
               cmd.code = amh_pkg::C_DN_MOVE;
               state_in = amh_pkg::S_DN0;
            end
         end
         amh_pkg::S_FIN: begin
            if (stat.empty || stat.op == amh_pkg::OP_EXTRACT) begin
               state_in = amh_pkg::S_OUT;
            end else begin
               cmd.code = amh_pkg::C_FIN0;
               state_in = amh_pkg::S_F1;
            end
         end
         amh_pkg::S_F1: begin
            cmd.code = amh_pkg::C_FIN1;
            state_in = amh_pkg::S_F2;
         end
         amh_pkg::S_F2: begin
            cmd.code = amh_pkg::C_FIN2;
            state_in = amh_pkg::S_OUT;
         end
         amh_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = amh_pkg::S_IDLE;
            end
         end
         default: state_in = amh_pkg::S_IDLE;
      endcase
   end

endmodule
